// ===== hdl/imu_sfp_pkg.sv =====
// ----------------------------------------------------------------------------
// imu_sfp_pkg
// shared types and constants for the imu serial frame parser
// ----------------------------------------------------------------------------
package imu_sfp_pkg;

    localparam logic [7:0] HDR_BYTE   = 8'h5A;
    localparam logic [7:0] TYPE_RATE  = 8'hAA;
    localparam logic [7:0] TYPE_ANGLE = 8'hBB;
    localparam logic [7:0] TYPE_ACCEL = 8'hCC;
    localparam logic [7:0] TYPE_QUAT  = 8'hDD;

    localparam int FRAME_LEN   = 11;
    localparam int STORE_DEPTH = 9;
    localparam int COUNT_W     = 4;
    localparam int IDX_W       = 4;

    // count value at which the checksum byte arrives
    localparam logic [COUNT_W-1:0] LAST_COUNT = COUNT_W'(FRAME_LEN - 1);

    typedef enum logic [1:0] {
        KIND_RATE  = 2'd0,
        KIND_ANGLE = 2'd1,
        KIND_ACCEL = 2'd2,
        KIND_QUAT  = 2'd3
    } frame_kind_t;

    typedef struct packed {
        frame_kind_t        frame_kind;
        logic signed [15:0] word_a;
        logic signed [15:0] word_b;
        logic signed [15:0] word_c;
        logic signed [15:0] word_d;
    } imu_sfp_result_t;

endpackage

// ===== hdl/imu_sfp_asm.sv =====
// ----------------------------------------------------------------------------
// imu_sfp_asm
// frame assembler: byte count, payload store, running checksum, frame check
// ----------------------------------------------------------------------------
module imu_sfp_asm
    import imu_sfp_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            step,      // byte is consumed this cycle
    input  logic [7:0]      rx_byte,
    output logic            emit,      // byte completes a good frame
    output imu_sfp_result_t result
);

    logic [COUNT_W-1:0] count_reg;
    logic [COUNT_W-1:0] count_next;
    logic [7:0]         sum_reg;
    logic [7:0]         sum_next;
    logic [7:0]         store_reg [STORE_DEPTH];
    logic [IDX_W-1:0]   store_idx;
    logic               store_wr;
    logic               at_start;
    logic               known;
    frame_kind_t        kind;

    assign at_start  = (count_reg == '0) || (count_reg > LAST_COUNT);
    assign store_idx = IDX_W'(count_reg - COUNT_W'(1));

    always_comb
    begin
        case (store_reg[0])
            TYPE_RATE:
            begin
                kind  = KIND_RATE;
                known = 1'b1;
            end
            TYPE_ANGLE:
            begin
                kind  = KIND_ANGLE;
                known = 1'b1;
            end
            TYPE_ACCEL:
            begin
                kind  = KIND_ACCEL;
                known = 1'b1;
            end
            TYPE_QUAT:
            begin
                kind  = KIND_QUAT;
                known = 1'b1;
            end
            default:
            begin
                kind  = KIND_RATE;
                known = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        count_next = count_reg;
        sum_next   = sum_reg;
        store_wr   = 1'b0;
        emit       = 1'b0;
        if (at_start)
        begin
            if (rx_byte == HDR_BYTE)
            begin
                sum_next   = HDR_BYTE;
                count_next = COUNT_W'(1);
            end
            else
            begin
                count_next = '0;
            end
        end
        else if (count_reg < LAST_COUNT)
        begin
            store_wr   = 1'b1;
            sum_next   = sum_reg + rx_byte;
            count_next = count_reg + COUNT_W'(1);
        end
        else
        begin
            count_next = '0;
            emit       = known && (rx_byte == sum_reg);
        end
    end

    // little-endian words from the stored type and payload bytes
    always_comb
    begin
        result.frame_kind = kind;
        result.word_a     = {store_reg[2], store_reg[1]};
        result.word_b     = {store_reg[4], store_reg[3]};
        result.word_c     = {store_reg[6], store_reg[5]};
        result.word_d     = (kind == KIND_QUAT) ? {store_reg[8], store_reg[7]} : 16'sd0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            sum_reg   <= '0;
        end
        else if (step)
        begin
            count_reg <= count_next;
            sum_reg   <= sum_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < STORE_DEPTH; i++)
        begin
            if (step && store_wr && (store_idx == IDX_W'(i)))
            begin
                store_reg[i] <= rx_byte;
            end
        end
    end

endmodule

// ===== hdl/imu_sfp_out.sv =====
// ----------------------------------------------------------------------------
// imu_sfp_out
// result register toward the output stream
// ----------------------------------------------------------------------------
module imu_sfp_out
    import imu_sfp_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            load,       // new result enters this cycle
    input  imu_sfp_result_t result,
    output logic            space,      // register free or draining this cycle
    output logic            out_valid,
    input  logic            out_ready,
    output imu_sfp_result_t out_data
);

    logic            valid_reg;
    logic            valid_next;
    imu_sfp_result_t data_reg;

    assign space     = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= result;
        end
    end

endmodule

// ===== hdl/imu_serial_frame_parser.sv =====
// ----------------------------------------------------------------------------
// imu_serial_frame_parser
// assembles 11-byte sensor frames from a byte stream and emits checked frames
// ----------------------------------------------------------------------------
//
// channel   dir  tdata                        tuser
// s_axis    in   [7:0] rx_byte                none
// m_axis    out  [15:0] word_a, [31:16] word_b frame_kind [1:0]
//                [47:32] word_c, [63:48] word_d
//
// one byte per cycle sustained while the result register has space; a byte
// is held in the input register, then passes the assembler into the result
// register; m_axis_tvalid rises once the checksum byte is through both
// reset clears the byte count, checksum and both valid flags; payload bytes
// are not reset
// a stalled result holds back the checksum byte of the next good frame and
// the bytes behind it; every other byte keeps flowing into the assembler
//
module imu_serial_frame_parser
    import imu_sfp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,   // [15:0] word_a, [31:16] word_b,
                                        // [47:32] word_c, [63:48] word_d
    output logic [1:0]  m_axis_tuser    // [1:0] frame_kind
);

    // input register
    logic            in_valid_reg;
    logic            in_valid_next;
    logic [7:0]      in_byte_reg;

    // assembler and result register handshake
    logic            advance;
    logic            emit;
    logic            space;
    imu_sfp_result_t asm_result;
    imu_sfp_result_t out_result;

    // a byte leaves the input register unless it would produce a result that
    // the full result register cannot take
    assign advance       = in_valid_reg && (!emit || space);
    assign s_axis_tready = !in_valid_reg || advance;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (s_axis_tvalid && s_axis_tready)
        begin
            in_valid_next = 1'b1;
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
        end
    end

    // payload byte: no reset needed
    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            in_byte_reg <= s_axis_tdata;
        end
    end

    // count, store, checksum and frame check
    imu_sfp_asm u_asm (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (advance),
        .rx_byte (in_byte_reg),
        .emit    (emit),
        .result  (asm_result)
    );

    // result register, loaded only for a checked frame
    imu_sfp_out u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (advance && emit),
        .result    (asm_result),
        .space     (space),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (out_result)
    );

    // pack the result fields, first word in the lowest bits
    assign m_axis_tdata = {out_result.word_d, out_result.word_c,
                           out_result.word_b, out_result.word_a};
    assign m_axis_tuser = out_result.frame_kind;

endmodule

// ===== test/imu_serial_frame_parser_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// imu_serial_frame_parser_test
// self-checking bench: byte stream in, checked sensor frames out
// ----------------------------------------------------------------------------
//
// bytes go in through s_axis with random bursts and gaps, and results are taken
// from m_axis with a changing stall pattern. A frame tracker follows the byte
// count, payload store and running sum the way the parser does. It queues
// every frame that should come out, and checks each m_axis transfer against
// the oldest one.
//
module imu_serial_frame_parser_test;
    import imu_sfp_pkg::*;

    localparam int STALL_LIMIT = 4000;   // cycles with no transfer on either side
    localparam int BYTE_TARGET = 1150;
    localparam int TAIL_CYCLES = 20;

    // ------------------------------------------------------------------------
    // frame tracker: predicts emitted frames and checks them in order
    // ------------------------------------------------------------------------
    class imu_frame_tracker;
        logic [COUNT_W-1:0] byte_cnt;
        logic [7:0]         frame_bytes [STORE_DEPTH];
        logic [7:0]         sum;
        imu_sfp_result_t    frames_due [$];
        int                 bytes_seen;
        int                 frames_good;
        int                 frames_bad_sum;
        int                 frames_bad_type;
        int                 kind_hits [4];
        int                 mismatches;
        int                 strays;

        function new();
            byte_cnt = '0;
            sum      = '0;
            foreach (frame_bytes[i])
                frame_bytes[i] = '0;
            foreach (kind_hits[i])
                kind_hits[i] = 0;
            bytes_seen      = 0;
            frames_good     = 0;
            frames_bad_sum  = 0;
            frames_bad_type = 0;
            mismatches      = 0;
            strays          = 0;
        endfunction

        // one accepted byte on s_axis
        function void note_byte(logic [7:0] b);
            imu_sfp_result_t r;
            frame_kind_t     kind;
            bit              known;
            bytes_seen++;
            if (byte_cnt == '0 || byte_cnt > LAST_COUNT) begin
                // waiting for a header; anything else is dropped
                if (b == HDR_BYTE) begin
                    sum      = HDR_BYTE;
                    byte_cnt = COUNT_W'(1);
                end
                else
                    byte_cnt = '0;
            end
            else if (byte_cnt < LAST_COUNT) begin
                // type or payload byte, a header value here is plain data
                frame_bytes[byte_cnt - 1] = b;
                sum      = sum + b;
                byte_cnt = byte_cnt + 1'b1;
            end
            else begin
                // checksum byte closes the frame either way
                byte_cnt = '0;
                known    = 1'b1;
                kind     = KIND_RATE;
                case (frame_bytes[0])
                    TYPE_RATE:  kind = KIND_RATE;
                    TYPE_ANGLE: kind = KIND_ANGLE;
                    TYPE_ACCEL: kind = KIND_ACCEL;
                    TYPE_QUAT:  kind = KIND_QUAT;
                    default:    known = 1'b0;
                endcase
                if (!known)
                    frames_bad_type++;
                else if (b != sum)
                    frames_bad_sum++;
                else begin
                    r.frame_kind = kind;
                    r.word_a     = {frame_bytes[2], frame_bytes[1]};
                    r.word_b     = {frame_bytes[4], frame_bytes[3]};
                    r.word_c     = {frame_bytes[6], frame_bytes[5]};
                    r.word_d     = (kind == KIND_QUAT) ?
                                   {frame_bytes[8], frame_bytes[7]} : 16'sd0;
                    frames_due.push_back(r);
                    frames_good++;
                    kind_hits[kind]++;
                end
            end
        endfunction

        // one accepted frame on m_axis
        function void check_frame(logic [1:0] kind_bits, logic [63:0] words);
            imu_sfp_result_t got;
            imu_sfp_result_t want;
            got.frame_kind = frame_kind_t'(kind_bits);
            got.word_a     = words[15:0];
            got.word_b     = words[31:16];
            got.word_c     = words[47:32];
            got.word_d     = words[63:48];
            if (frames_due.size() == 0) begin
                strays++;
                if (mismatches + strays <= 10)
                    $display("%0t: unexpected frame kind=%0d a=%0d b=%0d c=%0d d=%0d",
                             $time, got.frame_kind, got.word_a, got.word_b,
                             got.word_c, got.word_d);
                return;
            end
            want = frames_due.pop_front();
            if (got.frame_kind !== want.frame_kind || got.word_a !== want.word_a ||
                got.word_b !== want.word_b || got.word_c !== want.word_c ||
                got.word_d !== want.word_d) begin
                mismatches++;
                if (mismatches + strays <= 10) begin
                    $display("%0t: frame mismatch", $time);
                    $display("  expected kind=%0d a=%0d b=%0d c=%0d d=%0d",
                             want.frame_kind, want.word_a, want.word_b,
                             want.word_c, want.word_d);
                    $display("  actual   kind=%0d a=%0d b=%0d c=%0d d=%0d",
                             got.frame_kind, got.word_a, got.word_b,
                             got.word_c, got.word_d);
                end
            end
        endfunction

        function int pending();
            return frames_due.size();
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // clock, reset and block under test
    // ------------------------------------------------------------------------
    logic        clk;
    logic        rst_n         = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata  = 8'h00;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [63:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;

    imu_frame_tracker tracker;
    int               burst_left;
    int               frames_sent;
    int               idle_cycles;
    logic [6:0]       rx_cycle;
    int               rx_mode;

    imu_serial_frame_parser dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // receiver: a new stall pattern at each wrap of rx_cycle, which counts clock cycles
    // ------------------------------------------------------------------------
    initial
    begin
        rx_cycle = '0;
        rx_mode  = 0;
    end

    always @(posedge clk)
    begin
        if (rx_cycle == '0)
            rx_mode = $urandom_range(0, 3);
        case (rx_mode)
            0:       m_axis_tready <= 1'b1;
            1:       m_axis_tready <= ($urandom_range(0, 1) == 1);
            2:       m_axis_tready <= (rx_cycle[4:2] == 3'd0);  // long stalls
            default: m_axis_tready <= (rx_cycle[1:0] != 2'd0);
        endcase
        rx_cycle = rx_cycle + 1'b1;
    end

    // output transfers; values read here are the ones from before the edge
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            tracker.check_frame(m_axis_tuser, m_axis_tdata);
    end

    // watchdog on a quiet interface
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || !rst_n)
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("%0t: no transfer for %0d cycles, %0d frames outstanding",
                     $time, STALL_LIMIT, tracker.pending());
            $display("Test completed with failures");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // sender
    // ------------------------------------------------------------------------

    // one byte transfer, with a random gap whenever a burst runs out
    task automatic send_byte(input logic [7:0] b);
        if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 90) :
                                                       $urandom_range(1, 8);
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        tracker.note_byte(b);
    endtask

    // payload holds bytes 2..9, byte 2 in the low bits; sum_skew 0 gives a
    // good checksum
    task automatic send_frame(input logic [7:0] type_byte, input logic [63:0] payload,
                              input logic [7:0] sum_skew);
        logic [7:0] csum;
        csum = HDR_BYTE + type_byte;
        for (int i = 0; i < 8; i++)
            csum = csum + payload[8*i +: 8];
        send_byte(HDR_BYTE);
        send_byte(type_byte);
        for (int i = 0; i < 8; i++)
            send_byte(payload[8*i +: 8]);
        send_byte(csum + sum_skew);
        frames_sent++;
    endtask

    // payload byte leaning toward sign and range edges
    function automatic logic [7:0] pick_byte();
        case ($urandom_range(0, 11))
            0:       return 8'h00;
            1:       return 8'hFF;
            2:       return 8'h80;
            3:       return 8'h7F;
            4:       return HDR_BYTE;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic logic [7:0] pick_type();
        case ($urandom_range(0, 9))
            0, 1:    return TYPE_RATE;
            2, 3:    return TYPE_ANGLE;
            4, 5:    return TYPE_ACCEL;
            6, 7:    return TYPE_QUAT;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    initial
    begin
        logic [63:0] payload;
        logic [7:0]  skew;

        tracker     = new();
        burst_left  = 0;
        frames_sent = 0;
        idle_cycles = 0;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: stray bytes before any header are dropped
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(8'hA5);
        // every kind with extreme words; word_d must read zero outside quaternion
        send_frame(TYPE_RATE,  64'h0000_0000_0000_0000, 8'd0);
        send_frame(TYPE_ANGLE, 64'hFFFF_FFFF_FFFF_FFFF, 8'd0);
        send_frame(TYPE_ACCEL, 64'h7FFF_8000_FF7F_0080, 8'd0);
        send_frame(TYPE_QUAT,  64'h8000_7FFF_5A5A_005A, 8'd0);
        send_frame(TYPE_RATE,  64'h1234_5678_9ABC_DEF0, 8'd0);
        // bad checksum, unknown type, header value as type
        send_frame(TYPE_QUAT,  64'h0102_0304_0506_0708, 8'd1);
        send_frame(8'h00,      64'h1111_2222_3333_4444, 8'd0);
        send_frame(HDR_BYTE,   64'h5A5A_5A5A_5A5A_5A5A, 8'd0);

        // random: mostly well formed frames, some noise and cut-off frames
        while (tracker.bytes_seen < BYTE_TARGET) begin
            case ($urandom_range(0, 19))
                0: begin
                    // noise between frames, may hold a header that shifts framing
                    repeat ($urandom_range(1, 3)) send_byte(pick_byte());
                end
                1: begin
                    // frame cut short; the next header lands inside it as data
                    send_byte(HDR_BYTE);
                    send_byte(pick_type());
                    repeat ($urandom_range(0, 7)) send_byte(pick_byte());
                end
                default: ;
            endcase
            for (int i = 0; i < 8; i++)
                payload[8*i +: 8] = pick_byte();
            skew = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(1, 255)) : 8'd0;
            send_frame(pick_type(), payload, skew);

            // hold off until the parser has drained every frame owed
            if (frames_sent % 40 == 0) begin
                s_axis_tvalid <= 1'b0;
                @(posedge clk);
                while (tracker.pending() != 0)
                    @(posedge clk);
                burst_left = 0;
            end
        end

        // drain and watch for anything extra
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (tracker.pending() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("%0d bytes in %0d frames: %0d emitted, %0d bad checksum, %0d unknown type",
                 tracker.bytes_seen, frames_sent, tracker.frames_good,
                 tracker.frames_bad_sum, tracker.frames_bad_type);
        $display("kinds emitted: rate %0d, angle %0d, accel %0d, quat %0d; %0d mismatches",
                 tracker.kind_hits[0], tracker.kind_hits[1], tracker.kind_hits[2],
                 tracker.kind_hits[3], tracker.mismatches + tracker.strays);
        if (tracker.mismatches == 0 && tracker.strays == 0 && tracker.pending() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

// ===== files.f =====
hdl/imu_sfp_pkg.sv
hdl/imu_sfp_asm.sv
hdl/imu_sfp_out.sv
hdl/imu_serial_frame_parser.sv
test/imu_serial_frame_parser_test.sv
